@@ sv/pse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int STACK_DEPTH_DEF = 32;

    // character codes
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_DIV_ZERO  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd4;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } pse_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
    } pse_out_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } pse_op_t;

    typedef struct packed {
        logic              start;
        pse_op_t           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } pse_alu_req_t;

    typedef struct packed {
        logic              done;
        logic              div_zero;
        logic [DATA_W-1:0] result;
    } pse_alu_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_A,
        S_LOAD_A,
        S_ALU_WAIT,
        S_FIN,
        S_FIN_DATA
    } pse_state_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_SIGN,
        ALU_POW
    } pse_alu_state_t;

    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_operator(input logic [SYM_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET);
    endfunction

    // caret and anything else map to power; only operators reach the alu
    function automatic pse_op_t op_of(input logic [SYM_W-1:0] c);
        pse_op_t op;
        priority if (c == CH_PLUS)  op = OP_ADD;
        else if (c == CH_MINUS)     op = OP_SUB;
        else if (c == CH_STAR)      op = OP_MUL;
        else if (c == CH_SLASH)     op = OP_DIV;
        else                        op = OP_POW;
        return op;
    endfunction

endpackage

`default_nettype wire

@@ sv/postfix_stack_evaluator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid     | stall     | payload              | meaning
// ---------+-----------+-----------+----------------------+------------------------------
// input    | sym_valid | sym_stall | sym   (pse_in_t)     | one character, last marks end
// output   | res_valid | res_stall | res   (pse_out_t)    | top value and status at end
//
// one character at a time: whitespace and pushes pass S_DECODE; operators then pass S_READ_A,
// S_LOAD_A and S_ALU_WAIT, where / is a 32-step restoring divider (skipped on a zero divisor)
// and ^ one exponent bit/cycle. a last character adds S_FIN, and S_FIN_DATA to read the top.
// operators read both operands from the single read port, one after the other.
// asynchronous active-low reset clears depth, error and control; stack words are not cleared.
// a finished result waits in the output register; a last character stalls until it is taken.

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sym_valid,
    output logic                   sym_stall,
    input  wire pse_pkg::pse_in_t  sym,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output pse_pkg::pse_out_t      res
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    pse_state_t          state_reg, state_next;
    pse_in_t             in_reg, in_next;
    logic [CW-1:0]       depth_reg, depth_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic                res_valid_reg, res_valid_next;
    pse_out_t            res_reg, res_next;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [DATA_W-1:0]   mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [DATA_W-1:0]   mem_rd_data;

    pse_alu_req_t        alu_req;
    pse_alu_rsp_t        alu_rsp;

    logic [CW-1:0]       depth_m1;
    logic [CW-1:0]       depth_m2;
    logic                out_free;

    pse_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pse_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign depth_m1 = depth_reg - CW'(1);
    assign depth_m2 = depth_reg - CW'(2);
    assign out_free = !res_valid_reg || !res_stall;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= STS_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    // sequencer: decode, read-modify-write of the stack, end of expression
    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        b_next         = b_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = depth_reg[AW-1:0];
        mem_wr_data    = alu_rsp.result;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = depth_m1[AW-1:0];
        alu_req.start  = 1'b0;
        alu_req.op     = op_of(in_reg.symbol);
        alu_req.a      = mem_rd_data;
        alu_req.b      = b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sym_valid)
                begin
                    in_next    = sym;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = in_reg.last ? S_FIN : S_IDLE;
                if (!is_space(in_reg.symbol) && (err_reg == STS_OK))
                begin
                    if (is_operator(in_reg.symbol))
                    begin
                        if (depth_reg < CW'(2))
                        begin
                            err_next = STS_UNDERFLOW;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = S_READ_A;
                        end
                    end
                    else if (depth_reg >= CW'(STACK_DEPTH))
                    begin
                        err_next = STS_OVERFLOW;
                    end
                    else
                    begin
                        // digit or any other byte pushes code minus '0'
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {{(DATA_W-SYM_W){1'b0}}, in_reg.symbol}
                                      - DATA_W'(CH_ZERO);
                        depth_next  = depth_reg + CW'(1);
                    end
                end
            end
            S_READ_A:
            begin
                // top value arrives, fetch the one beneath it
                b_next      = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = depth_m2[AW-1:0];
                state_next  = S_LOAD_A;
            end
            S_LOAD_A:
            begin
                alu_req.start = 1'b1;
                depth_next    = depth_m2;
                state_next    = S_ALU_WAIT;
            end
            S_ALU_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.div_zero)
                    begin
                        err_next = STS_DIV_ZERO;
                    end
                    else
                    begin
                        mem_wr_en  = 1'b1;
                        depth_next = depth_reg + CW'(1);
                    end
                    state_next = in_reg.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if ((err_reg != STS_OK) || (depth_reg == '0))
                begin
                    if (out_free)
                    begin
                        res_valid_next = 1'b1;
                        res_next.value = '0;
                        res_next.status = (err_reg != STS_OK) ? err_reg : STS_EMPTY;
                        depth_next     = '0;
                        err_next       = STS_OK;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_FIN_DATA;
                end
            end
            S_FIN_DATA:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_next.value  = $signed(mem_rd_data);
                    res_next.status = STS_OK;
                    depth_next      = '0;
                    err_next        = STS_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sym_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != STS_OK)) |-> (res.value == '0))
        else $error("nonzero value with error status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.status <= STS_EMPTY))
        else $error("status code out of range");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == S_ALU_WAIT))
        else $error("alu completion outside wait state");

endmodule

`default_nettype wire

@@ sv/pse_stack_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pse_stack_mem #(
    parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [pse_pkg::DATA_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [pse_pkg::DATA_W-1:0] rd_data
);
    import pse_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // one write port, one registered read port; read data holds without rd_en
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/pse_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pse_alu (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pse_pkg::pse_alu_req_t req,
    output pse_pkg::pse_alu_rsp_t      rsp
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    pse_alu_state_t    state_reg, state_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] exp_reg, exp_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic              dz_reg, dz_next;
    logic [DATA_W-1:0] result_reg, result_next;

    logic [DATA_W-1:0] prod_acc;
    logic [DATA_W-1:0] prod_sq;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;

    // multipliers, low word only; acc times sq is shared by multiply and power
    assign prod_acc = acc_reg * sq_reg;
    assign prod_sq  = sq_reg * sq_reg;

    // restoring divide step: acc holds dividend shifting into quotient
    assign rem_shift = {rem_reg, acc_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        dz_reg     <= dz_next;
        result_reg <= result_next;
    end

    // operation sequencer
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        dz_next     = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ALU_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        OP_ADD:
                        begin
                            result_next = req.a + req.b;
                            done_next   = 1'b1;
                        end
                        OP_SUB:
                        begin
                            result_next = req.a - req.b;
                            done_next   = 1'b1;
                        end
                        OP_MUL:
                        begin
                            acc_next   = req.a;
                            sq_next    = req.b;
                            state_next = ALU_MUL;
                        end
                        OP_DIV:
                        begin
                            if (req.b == '0)
                            begin
                                dz_next   = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                acc_next   = req.a[DATA_W-1] ? -req.a : req.a;
                                sq_next    = req.b[DATA_W-1] ? -req.b : req.b;
                                rem_next   = '0;
                                cnt_next   = '1;
                                neg_next   = req.a[DATA_W-1] ^ req.b[DATA_W-1];
                                state_next = ALU_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            // negative exponent gives one
                            if (req.b[DATA_W-1])
                            begin
                                result_next = DATA_W'(1);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                acc_next   = DATA_W'(1);
                                sq_next    = req.a;
                                exp_next   = req.b;
                                state_next = ALU_POW;
                            end
                        end
                        default:
                        begin
                            result_next = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            ALU_MUL:
            begin
                result_next = prod_acc;
                done_next   = 1'b1;
                state_next  = ALU_IDLE;
            end
            ALU_DIV:
            begin
                if (!rem_diff[DATA_W])
                begin
                    rem_next = rem_diff[DATA_W-1:0];
                    acc_next = {acc_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DATA_W-1:0];
                    acc_next = {acc_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ALU_SIGN;
                end
            end
            ALU_SIGN:
            begin
                result_next = neg_reg ? -acc_reg : acc_reg;
                done_next   = 1'b1;
                state_next  = ALU_IDLE;
            end
            ALU_POW:
            begin
                // square and multiply, one exponent bit per cycle
                if (exp_reg == '0)
                begin
                    result_next = acc_reg;
                    done_next   = 1'b1;
                    state_next  = ALU_IDLE;
                end
                else
                begin
                    if (exp_reg[0])
                    begin
                        acc_next = prod_acc;
                    end
                    sq_next  = prod_sq;
                    exp_next = exp_reg >> 1;
                end
            end
            default:
            begin
                state_next = ALU_IDLE;
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign rsp.result   = result_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

// expected-result store and stack predictor for the postfix evaluator
class postfix_evaluator_model;
    logic [pse_pkg::DATA_W-1:0]   stack_words [pse_pkg::STACK_DEPTH_DEF];
    int unsigned                  stack_count;
    logic [pse_pkg::STATUS_W-1:0] sticky_err;
    pse_pkg::pse_out_t            due_results [$];
    int unsigned                  n_fail;

    function new();
        stack_count = 0;
        sticky_err  = pse_pkg::STS_OK;
        n_fail      = 0;
    endfunction

    function bit is_blank(logic [pse_pkg::SYM_W-1:0] c);
        return (c == pse_pkg::CH_SPACE) || (c >= pse_pkg::CH_TAB && c <= pse_pkg::CH_CR);
    endfunction

    function bit is_operator(logic [pse_pkg::SYM_W-1:0] c);
        case (c)
            pse_pkg::CH_PLUS, pse_pkg::CH_MINUS, pse_pkg::CH_STAR,
            pse_pkg::CH_SLASH, pse_pkg::CH_CARET: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // square-and-multiply, wrapping; negative exponent gives one
    function logic [31:0] wrapped_power(logic [31:0] base, logic [31:0] expo);
        logic [31:0] acc;
        logic [31:0] sq;
        logic [31:0] e;
        acc = 32'd1;
        sq  = base;
        e   = expo;
        if (e[31])
        begin
            return 32'd1;
        end
        while (e != 32'd0)
        begin
            if (e[0])
            begin
                acc = acc * sq;
            end
            sq = sq * sq;
            e  = e >> 1;
        end
        return acc;
    endfunction

    function int unsigned pending();
        return due_results.size();
    endfunction

    // note one accepted character and predict the result it closes, if any
    function void take_symbol(pse_pkg::pse_in_t item);
        logic [pse_pkg::SYM_W-1:0]  c;
        logic [pse_pkg::DATA_W-1:0] lhs;
        logic [pse_pkg::DATA_W-1:0] rhs;
        logic [pse_pkg::DATA_W-1:0] outcome;
        pse_pkg::pse_out_t          due;
        c = item.symbol;
        if (!is_blank(c) && sticky_err == pse_pkg::STS_OK)
        begin
            if (is_operator(c))
            begin
                if (stack_count < 2)
                begin
                    sticky_err = pse_pkg::STS_UNDERFLOW;
                end
                else
                begin
                    rhs = stack_words[stack_count - 1];
                    lhs = stack_words[stack_count - 2];
                    stack_count -= 2;
                    if (c == pse_pkg::CH_SLASH && rhs == '0)
                    begin
                        sticky_err = pse_pkg::STS_DIV_ZERO;
                    end
                    else
                    begin
                        case (c)
                            pse_pkg::CH_PLUS:  outcome = lhs + rhs;
                            pse_pkg::CH_MINUS: outcome = lhs - rhs;
                            pse_pkg::CH_STAR:  outcome = lhs * rhs;
                            pse_pkg::CH_SLASH:
                            begin
                                // most negative over minus one wraps back to itself
                                if (lhs == 32'h8000_0000 && rhs == '1)
                                begin
                                    outcome = lhs;
                                end
                                else
                                begin
                                    outcome = $signed(lhs) / $signed(rhs);
                                end
                            end
                            default: outcome = wrapped_power(lhs, rhs);
                        endcase
                        stack_words[stack_count] = outcome;
                        stack_count++;
                    end
                end
            end
            else if (stack_count >= pse_pkg::STACK_DEPTH_DEF)
            begin
                sticky_err = pse_pkg::STS_OVERFLOW;
            end
            else
            begin
                stack_words[stack_count] = {24'd0, c} - {24'd0, pse_pkg::CH_ZERO};
                stack_count++;
            end
        end
        // end of expression: report and clear
        if (item.last)
        begin
            due.value  = '0;
            due.status = sticky_err;
            if (sticky_err == pse_pkg::STS_OK)
            begin
                if (stack_count == 0)
                begin
                    due.status = pse_pkg::STS_EMPTY;
                end
                else
                begin
                    due.value = stack_words[stack_count - 1];
                end
            end
            due_results.push_back(due);
            stack_count = 0;
            sticky_err  = pse_pkg::STS_OK;
        end
    endfunction

    // compare one delivered result with the oldest prediction
    function void match_result(pse_pkg::pse_out_t got);
        pse_pkg::pse_out_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: unexpected result value %0d status %0d", $time,
                     $signed(got.value), got.status);
            n_fail++;
            return;
        end
        want = due_results.pop_front();
        if (got.value !== want.value)
        begin
            $display("%0t: value mismatch, expected %0d actual %0d", $time,
                     $signed(want.value), $signed(got.value));
            n_fail++;
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     want.status, got.status);
            n_fail++;
        end
    endfunction
endclass

module tb;
    import pse_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 11;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 560;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     sym_valid = 1'b0;
    pse_in_t  sym       = '0;
    logic     sym_stall;
    logic     res_valid;
    logic     res_stall = 1'b0;
    pse_out_t res;

    int       send_idle    = 0;
    int       recv_idle    = 0;
    bit       hold_request = 1'b0;
    int       items_sent   = 0;
    int       quiet        = 0;
    logic [SYM_W-1:0] expr_text [$];

    postfix_evaluator_model evaluator = new();

    postfix_stack_evaluator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // offer one character, with random idle cycles ahead of it
    task automatic send_symbol(input logic [SYM_W-1:0] c, input logic fin);
        pse_in_t item;
        item.symbol = c;
        item.last   = fin;
        while ($urandom_range(0, 99) < send_idle)
        begin
            sym_valid <= 1'b0;
            @(posedge clk);
        end
        sym_valid <= 1'b1;
        sym       <= item;
        @(posedge clk);
        while (sym_stall)
        begin
            @(posedge clk);
        end
        evaluator.take_symbol(item);
        items_sent++;
    endtask

    // send the buffered expression, marking its final character
    task automatic send_expr_text();
        for (int i = 0; i < expr_text.size(); i++)
        begin
            send_symbol(expr_text[i], i == expr_text.size() - 1);
        end
        expr_text.delete();
    endtask

    function automatic void load_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            expr_text.push_back(s[i]);
        end
    endfunction

    function automatic logic [SYM_W-1:0] pick_blank();
        logic [SYM_W-1:0] c;
        c = CH_SPACE;
        if ($urandom_range(0, 5) != 0)
        begin
            c = CH_TAB + SYM_W'($urandom_range(0, 4));
        end
        return c;
    endfunction

    // mostly digits, sometimes any byte that pushes
    function automatic logic [SYM_W-1:0] pick_operand();
        logic [SYM_W-1:0] c;
        c = CH_ZERO + SYM_W'($urandom_range(0, 9));
        if ($urandom_range(0, 99) < 25)
        begin
            c = SYM_W'($urandom_range(0, 255));
            while (evaluator.is_blank(c) || evaluator.is_operator(c))
            begin
                c = SYM_W'($urandom_range(0, 255));
            end
        end
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic void add_token(input logic [SYM_W-1:0] c);
        if ($urandom_range(0, 99) < 12)
        begin
            expr_text.push_back(pick_blank());
        end
        expr_text.push_back(c);
    endfunction

    // result side: check every transaction, stall at random or on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                evaluator.match_result(res);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < recv_idle);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (sym_valid && !sym_stall) || (res_valid && !res_stall))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin : stimulus
        int mode;
        int n;
        int d;
        int left;
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operator, truncation, wraps, errors, empty, byte extremes
        load_text("95-3*1+");
        send_expr_text();
        load_text("!2/");
        send_expr_text();
        load_text("2!^");
        send_expr_text();
        load_text("2O^01-/");
        send_expr_text();
        load_text("50/");
        send_expr_text();
        load_text("+5");
        send_expr_text();
        load_text(" \t");
        send_expr_text();
        expr_text.push_back(8'hFF);
        send_expr_text();
        expr_text.push_back(8'h00);
        send_expr_text();

        // random phases: receiver idles most, then sender idles most, then neither
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 20 : (phase == 1) ? 54 : 0;
            recv_idle = (phase == 0) ? 54 : (phase == 1) ? 20 : 0;
            if (phase == 2)
            begin
                // long receiver hold-off while short expressions keep coming
                hold_request = 1'b1;
                repeat (24)
                begin
                    send_symbol(CH_ZERO + SYM_W'($urandom_range(0, 9)), 1'b1);
                end
            end
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
            begin
                mode = $urandom_range(0, 99);
                if (mode < 8)
                begin
                    // noise, possibly leaving a partial expression behind
                    repeat ($urandom_range(1, 6))
                    begin
                        send_symbol(SYM_W'($urandom_range(0, 255)),
                                    $urandom_range(0, 3) == 0);
                    end
                end
                else
                begin
                    if (mode < 14)
                    begin
                        // deep stack, pushes first, often past the top
                        n = $urandom_range(28, 36);
                        repeat (n)
                        begin
                            add_token(pick_operand());
                        end
                        repeat (n - 1)
                        begin
                            add_token(pick_operator());
                        end
                    end
                    else
                    begin
                        // well-formed interleaved expression
                        n    = $urandom_range(1, 8);
                        d    = 0;
                        left = n;
                        while (left > 0 || d > 1)
                        begin
                            if (left > 0 && (d < 2 || $urandom_range(0, 1) == 1))
                            begin
                                add_token(pick_operand());
                                left--;
                                d++;
                            end
                            else
                            begin
                                add_token(pick_operator());
                                d--;
                            end
                        end
                    end
                    if ($urandom_range(0, 99) < 5)
                    begin
                        expr_text.push_back(pick_blank());
                    end
                    send_expr_text();
                end
            end
        end
        sym_valid <= 1'b0;

        while (evaluator.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (evaluator.n_fail == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
